>>> src/assert_macros.svh
// Assertion helpers for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> src/bfpa_pkg.sv
//------------------------------------------------------------------------------
// bfpa_pkg
// Shared types and constants for the best-fit pool allocator.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package bfpa_pkg;
	localparam int DefMaxChunks = 64;
	localparam int DefSizeBits  = 40;
	localparam int AddrW  = 48;
	localparam int StatW  = 40;
	localparam int AlignW = 17;
	localparam int CntW   = 7;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_PROBE = 2'd2,
		CMD_SPARE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		CODE_OK      = 3'd0,
		CODE_ZERO    = 3'd1,
		CODE_NOFIT   = 3'd2,
		CODE_UNKNOWN = 3'd3,
		CODE_FULL    = 3'd4
	} code_t;

	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_POOL  = 2'd1;
	localparam logic [1:0] REG_ALIGN = 2'd2;

	// Operation broadcast from the sequencer to the cell chain each cycle
	typedef enum logic [2:0] {
		OP_NONE,
		OP_INIT,     // every cell clears, head cell loads pool
		OP_SHIFT_UP, // cells above split point take left neighbor
		OP_SHIFT_DN, // cells at and above index take right neighbor
		OP_WRITE     // write one cell at index
	} op_t;
endpackage

>>> src/bfpa_cell.sv
//------------------------------------------------------------------------------
// bfpa_cell
// One chunk-table entry; shifts to/from neighbors or takes a direct write.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module bfpa_cell #(
	parameter int SIZE_BITS = 40,
	parameter int IDX_W = 6,
	parameter int MY_IDX = 0
) (
	input  logic                  clk,
	input  bfpa_pkg::op_t         op,
	input  logic [IDX_W-1:0]      idx,
	input  logic [SIZE_BITS-1:0]  wr_off,
	input  logic [SIZE_BITS-1:0]  wr_len,
	input  logic                  wr_busy,
	input  logic [SIZE_BITS-1:0]  lo_off,
	input  logic [SIZE_BITS-1:0]  lo_len,
	input  logic                  lo_busy,
	input  logic [SIZE_BITS-1:0]  hi_off,
	input  logic [SIZE_BITS-1:0]  hi_len,
	input  logic                  hi_busy,
	output logic [SIZE_BITS-1:0]  off,
	output logic [SIZE_BITS-1:0]  len,
	output logic                  busy
);
	import bfpa_pkg::*;
	localparam logic [IDX_W-1:0] Me = IDX_W'(MY_IDX);

	logic [SIZE_BITS-1:0] off_q, len_q;
	logic                 busy_q;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_INIT: begin
				off_q  <= '0;
				len_q  <= (Me == '0) ? wr_len : '0;
				busy_q <= 1'b0;
			end
			OP_SHIFT_UP: if (Me > idx) begin
				off_q <= lo_off; len_q <= lo_len; busy_q <= lo_busy;
			end
			OP_SHIFT_DN: if (Me >= idx) begin
				off_q <= hi_off; len_q <= hi_len; busy_q <= hi_busy;
			end
			OP_WRITE: if (Me == idx) begin
				off_q <= wr_off; len_q <= wr_len; busy_q <= wr_busy;
			end
			default: ;
		endcase
	end

	assign off  = off_q;
	assign len  = len_q;
	assign busy = busy_q;
endmodule

>>> src/best_fit_pool_allocator.sv
// Best-fit pool allocator. One command beat in, one result beat out. Commands
// run one at a time on a sequencer that walks the chunk table, a chain of
// MAX_CHUNKS register cells, one entry per cycle. Every command is accepted
// in ST_IDLE. Allocate then rounds the size up to the alignment (remainder
// found one bit per cycle), scans for the best fit, and writes the table in
// ST_SPLIT and ST_SPLIT2, with ST_MRG_HI after them for a split. Free looks
// the address up, then merges through ST_MRG_HI, ST_MRG_LO, ST_PRED and
// ST_PRED_SH as the neighbors allow; probe and an unknown address only look
// up. Every command ends with a statistics walk and an output state that
// lasts until out_ready. The worst case is an allocate that splits a chunk.
// A config write is taken in ST_IDLE and starts a table init the following
// cycle, so the first command after reset release or after a config write
// is taken once ST_INIT has passed and the sequencer is back in ST_IDLE.
//------------------------------------------------------------------------------
// best_fit_pool_allocator
// Top level: config registers, command sequencer, chunk cell chain.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module best_fit_pool_allocator #(
	parameter int MAX_CHUNKS = bfpa_pkg::DefMaxChunks,
	parameter int SIZE_BITS  = bfpa_pkg::DefSizeBits
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [bfpa_pkg::AddrW-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   cmd,
	input  logic [bfpa_pkg::StatW-1:0]   request_size,
	input  logic [bfpa_pkg::AddrW-1:0]   address,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bfpa_pkg::AddrW-1:0]   result_address,
	output logic [2:0]                   code,
	output logic                         is_tracked,
	output logic [bfpa_pkg::StatW-1:0]   allocated_bytes,
	output logic [bfpa_pkg::CntW-1:0]    allocated_chunks,
	output logic [bfpa_pkg::StatW-1:0]   available_bytes,
	output logic [bfpa_pkg::StatW-1:0]   fragmented_bytes,
	output logic [bfpa_pkg::CntW-1:0]    fragment_chunks,
	output logic [bfpa_pkg::StatW-1:0]   tail_free_bytes
);
	import bfpa_pkg::*;
	localparam int IdxW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int NW    = $clog2(MAX_CHUNKS + 1);
	localparam int NeedW = (SIZE_BITS > StatW) ? SIZE_BITS : StatW + 1;
	localparam int DivW  = $clog2(StatW + 2);
	localparam logic [NW-1:0]   MaxN     = NW'(MAX_CHUNKS);
	localparam logic [DivW-1:0] DivSteps = DivW'(StatW + 1);

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_ALIGN, ST_SCAN, ST_SPLIT, ST_SPLIT2, ST_FIND,
		ST_MRG_HI, ST_MRG_LO, ST_PRED, ST_PRED_SH, ST_STAT, ST_OUT
	} state_t;

	state_t state_q;
	logic [AddrW-1:0]     base_q;
	logic [StatW-1:0]     pool_q;
	logic [AlignW-1:0]    align_q;
	logic [NW-1:0]        count_q;
	logic [NW-1:0]        ptr_q;
	logic [1:0]           cmd_q;
	logic [AddrW-1:0]     addr_q;
	logic [NeedW-1:0]     need_q;
	logic                 found_q;
	logic [IdxW-1:0]      best_q;
	logic [SIZE_BITS-1:0] best_len_q;
	logic [SIZE_BITS-1:0] best_off_q;
	logic [AddrW-1:0]     res_addr_q;
	code_t                code_q;
	logic                 trk_q;
	logic [StatW-1:0]     ab_q, av_q, fb_q, tb_q;
	logic [CntW-1:0]      ac_q, fc_q;
	logic [StatW:0]       align_acc_q;
	logic [AlignW-1:0]    align_rem_q;
	logic [DivW-1:0]      align_cnt_q;

	op_t                  op;
	logic [IdxW-1:0]      op_idx;
	logic [SIZE_BITS-1:0] wr_off, wr_len;
	logic                 wr_busy;

	logic [SIZE_BITS-1:0] c_off  [MAX_CHUNKS];
	logic [SIZE_BITS-1:0] c_len  [MAX_CHUNKS];
	logic                 c_busy [MAX_CHUNKS];

	genvar g;
	generate
		for (g = 0; g < MAX_CHUNKS; g++) begin : g_cell
			localparam int Lo = (g == 0) ? 0 : g - 1;
			localparam int Hi = (g == MAX_CHUNKS - 1) ? g : g + 1;
			bfpa_cell #(.SIZE_BITS(SIZE_BITS), .IDX_W(IdxW), .MY_IDX(g)) u_cell (
				.clk, .op, .idx(op_idx), .wr_off, .wr_len, .wr_busy,
				.lo_off(c_off[Lo]), .lo_len(c_len[Lo]), .lo_busy(c_busy[Lo]),
				.hi_off(c_off[Hi]), .hi_len(c_len[Hi]), .hi_busy(c_busy[Hi]),
				.off(c_off[g]), .len(c_len[g]), .busy(c_busy[g])
			);
		end
	endgenerate

	logic [IdxW-1:0]      pi;
	logic [SIZE_BITS-1:0] p_off, p_len;
	logic                 p_busy;
	logic [AddrW-1:0]     p_addr;
	logic [SIZE_BITS-1:0] nxt_len;
	logic                 nxt_busy;
	logic                 p_last;
	logic [AlignW-1:0]    a_eff;
	logic [SIZE_BITS-1:0] merged;
	logic                 do_split;
	logic [StatW:0]       align_x;
	logic [AlignW:0]      rem_sh;
	logic [AlignW-1:0]    rem_nxt;

	assign pi       = ptr_q[IdxW-1:0];
	assign p_off    = c_off[pi];
	assign p_len    = c_len[pi];
	assign p_busy   = c_busy[pi];
	assign p_addr   = base_q + AddrW'(p_off);
	assign nxt_len  = c_len[IdxW'(ptr_q + 1'b1)];
	assign nxt_busy = c_busy[IdxW'(ptr_q + 1'b1)];
	assign p_last   = (ptr_q + 1'b1) == count_q;
	assign a_eff    = (align_q == '0) ? AlignW'(1) : align_q;
	assign do_split = NeedW'(best_len_q) != need_q;

	// size + align - 1; rounded size is this minus its remainder by align
	assign align_x = {1'b0, request_size} + (StatW+1)'(a_eff) - 1'b1;
	assign rem_sh  = {align_rem_q, align_acc_q[StatW]};
	assign rem_nxt = (rem_sh >= {1'b0, a_eff}) ? AlignW'(rem_sh - {1'b0, a_eff})
		: AlignW'(rem_sh);

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		op = OP_NONE; op_idx = pi; wr_off = p_off; wr_len = p_len; wr_busy = p_busy;
		merged = p_len + nxt_len;
		unique case (state_q)
			ST_INIT: begin
				op = OP_INIT; wr_len = SIZE_BITS'(pool_q);
			end
			ST_SPLIT: if (do_split) begin
				op = OP_SHIFT_UP; op_idx = best_q;
			end
			ST_SPLIT2: begin
				op = OP_WRITE; op_idx = best_q;
				wr_off = best_off_q; wr_len = SIZE_BITS'(need_q); wr_busy = 1'b1;
			end
			ST_MRG_HI: begin
				op = OP_WRITE; wr_busy = 1'b0;
				if (cmd_q == CMD_ALLOC) begin
					// remainder right after the granted chunk
					wr_off = best_off_q + SIZE_BITS'(need_q);
					wr_len = best_len_q - SIZE_BITS'(need_q);
				end else if (!p_last && !nxt_busy) wr_len = merged;
			end
			ST_PRED: if (!p_busy) begin
				op = OP_WRITE; wr_len = merged;
			end
			ST_MRG_LO, ST_PRED_SH: begin
				op = OP_SHIFT_DN; op_idx = IdxW'(ptr_q + 1'b1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			base_q <= '0; pool_q <= StatW'(1048576); align_q <= AlignW'(256);
			count_q <= '0; ptr_q <= '0;
			cmd_q <= '0; addr_q <= '0; need_q <= '0; found_q <= 1'b0;
			best_q <= '0; best_len_q <= '0; best_off_q <= '0;
			res_addr_q <= '0; code_q <= CODE_OK; trk_q <= 1'b0;
			align_acc_q <= '0; align_rem_q <= '0; align_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					count_q <= NW'(1); state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cfg_valid) begin
						unique case (cfg_index)
							REG_BASE:  begin base_q <= cfg_data; state_q <= ST_INIT; end
							REG_POOL:  begin pool_q <= StatW'(cfg_data); state_q <= ST_INIT; end
							REG_ALIGN: begin align_q <= AlignW'(cfg_data); state_q <= ST_INIT; end
							default: ;
						endcase
					end else if (in_valid) begin
						cmd_q <= cmd; addr_q <= address;
						res_addr_q <= '0; code_q <= CODE_OK; trk_q <= 1'b0;
						found_q <= 1'b0; ptr_q <= '0;
						align_acc_q <= align_x; need_q <= NeedW'(align_x);
						align_rem_q <= '0; align_cnt_q <= DivSteps;
						unique case (cmd_t'(cmd))
							CMD_ALLOC: begin
								if (request_size == '0) begin
									code_q <= CODE_ZERO; state_q <= ST_STAT;
								end else state_q <= ST_ALIGN;
							end
							CMD_FREE, CMD_PROBE: state_q <= ST_FIND;
							default: state_q <= ST_STAT;
						endcase
					end
				end
				ST_ALIGN: begin
					// restoring remainder, one bit per cycle, MSB first
					align_acc_q <= {align_acc_q[StatW-1:0], 1'b0};
					align_rem_q <= rem_nxt;
					align_cnt_q <= align_cnt_q - 1'b1;
					if (align_cnt_q == DivW'(1)) begin
						need_q <= need_q - NeedW'(rem_nxt);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ptr_q < count_q) begin
						if (!p_busy && NeedW'(p_len) >= need_q &&
								(!found_q || p_len < best_len_q)) begin
							found_q <= 1'b1; best_q <= pi; best_len_q <= p_len; best_off_q <= p_off;
						end
						ptr_q <= ptr_q + 1'b1;
					end else if (!found_q) begin
						code_q <= CODE_NOFIT; ptr_q <= '0; state_q <= ST_STAT;
					end else if (do_split && count_q >= MaxN) begin
						code_q <= CODE_FULL; ptr_q <= '0; state_q <= ST_STAT;
					end else state_q <= ST_SPLIT;
				end
				ST_SPLIT: begin
					if (do_split) count_q <= count_q + 1'b1;
					state_q <= ST_SPLIT2;
				end
				ST_SPLIT2: begin
					// remainder cell (if split) was copied from best; fix it next
					ptr_q <= NW'(best_q) + 1'b1;
					res_addr_q <= base_q + AddrW'(best_off_q);
					state_q <= do_split ? ST_MRG_HI : ST_STAT;
					if (!do_split) ptr_q <= '0;
				end
				ST_FIND: begin
					if (ptr_q < count_q && p_addr == addr_q) begin
						if (cmd_q == CMD_PROBE) begin
							trk_q <= p_busy; ptr_q <= '0; state_q <= ST_STAT;
						end else state_q <= ST_MRG_HI;
					end else if (ptr_q + 1'b1 >= count_q || ptr_q >= count_q) begin
						if (cmd_q == CMD_FREE) code_q <= CODE_UNKNOWN;
						ptr_q <= '0; state_q <= ST_STAT;
					end else ptr_q <= ptr_q + 1'b1;
				end
				ST_MRG_HI: begin
					if (cmd_q == CMD_ALLOC) begin
						ptr_q <= '0; state_q <= ST_STAT;
					end else if (!p_last && !nxt_busy) begin
						count_q <= count_q - 1'b1; state_q <= ST_MRG_LO;
					end else if (ptr_q == '0) state_q <= ST_STAT;
					else begin
						ptr_q <= ptr_q - 1'b1; state_q <= ST_PRED;
					end
				end
				ST_MRG_LO: begin
					if (ptr_q == '0) state_q <= ST_STAT;
					else begin
						ptr_q <= ptr_q - 1'b1; state_q <= ST_PRED;
					end
				end
				// pointer on the predecessor; the freed chunk is its neighbor
				ST_PRED: begin
					if (!p_busy) begin
						count_q <= count_q - 1'b1; state_q <= ST_PRED_SH;
					end else begin
						ptr_q <= '0; state_q <= ST_STAT;
					end
				end
				ST_PRED_SH: begin
					ptr_q <= '0; state_q <= ST_STAT;
				end
				ST_STAT: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == count_q) state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			ab_q <= '0; av_q <= '0; fb_q <= '0; tb_q <= '0; ac_q <= '0; fc_q <= '0;
		end else if (state_q == ST_STAT && ptr_q < count_q) begin
			if (p_busy) begin
				ab_q <= ab_q + StatW'(p_len); ac_q <= ac_q + 1'b1;
			end else begin
				av_q <= av_q + StatW'(p_len);
				if (!p_last) begin
					fb_q <= fb_q + StatW'(p_len); fc_q <= fc_q + 1'b1;
				end else tb_q <= StatW'(p_len);
			end
		end
	end

	assign result_address   = res_addr_q;
	assign code             = code_q;
	assign is_tracked       = trk_q;
	assign allocated_bytes  = ab_q;
	assign allocated_chunks = ac_q;
	assign available_bytes  = av_q;
	assign fragmented_bytes = fb_q;
	assign fragment_chunks  = fc_q;
	assign tail_free_bytes  = tb_q;
endmodule

>>> src/bfpa_checker.sv
//------------------------------------------------------------------------------
// bfpa_checker
// Port-level checks for the allocator, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bfpa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       cfg_ready,
	input logic [2:0] code,
	input logic       is_tracked
);
	import bfpa_pkg::*;
	`CHK_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready,
		"input taken while busy")
	`CHK_IMPL(a_no_out_when_idle, clk, arst_n, in_ready || cfg_ready, !out_valid,
		"result shown while idle")
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid,
		"result dropped before taken")
	`CHK_IMPL(a_code_range, clk, arst_n, out_valid, code <= CODE_FULL,
		"bad status code")
	`CHK_IMPL(a_tracked_ok, clk, arst_n, out_valid && is_tracked, code == CODE_OK,
		"tracked with error")
endmodule

bind best_fit_pool_allocator bfpa_checker u_bfpa_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cfg_ready,
	.code, .is_tracked
);

>>> tb/tb_best_fit_pool_allocator.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_best_fit_pool_allocator
// Self-checking bench for the best-fit pool allocator. A scoreboard keeps its
// own chunk table, predicts the code and pool statistics for every accepted
// command and checks each result beat in order. Stimulus covers directed
// corner cases, a table-fill run, and random command mixes under several pool
// settings. Both sides idle at random, and the result side holds off once so
// that the command side backs up.
//------------------------------------------------------------------------------
module tb_best_fit_pool_allocator;
	import bfpa_pkg::*;

	localparam int Slots      = 64;
	localparam int StallLimit = 4000;

	typedef struct {
		logic [47:0] addr;
		logic [2:0]  code;
		logic        tracked;
		logic [39:0] used_bytes;
		logic [6:0]  used_chunks;
		logic [39:0] free_bytes;
		logic [39:0] frag_bytes;
		logic [6:0]  frag_chunks;
		logic [39:0] tail_bytes;
	} pool_result_t;

	class pool_scoreboard;
		bit [47:0] base;
		bit [39:0] pool;
		bit [16:0] align;
		bit [39:0] offs[Slots];
		bit [39:0] lens[Slots];
		bit        busy[Slots];
		int        count;
		pool_result_t pending_q[$];
		int        errors;

		function new();
			base = 0;
			pool = 40'd1048576;
			align = 17'd256;
			errors = 0;
			clear_table();
		endfunction

		function void clear_table();
			for (int i = 0; i < Slots; i++) begin
				offs[i] = 0;
				lens[i] = 0;
				busy[i] = 0;
			end
			lens[0] = pool;
			count = 1;
		endfunction

		function void configure(logic [1:0] idx, logic [47:0] data);
			case (idx)
				REG_BASE:  base = data;
				REG_POOL:  pool = data[39:0];
				REG_ALIGN: align = data[16:0];
				default: return;
			endcase
			clear_table();
		endfunction

		function bit [47:0] chunk_address(int i);
			return base + {8'd0, offs[i]};
		endfunction

		function int locate(bit [47:0] a);
			for (int i = 0; i < count; i++)
				if (chunk_address(i) == a)
					return i;
			return -1;
		endfunction

		function void drop_entry(int idx);
			for (int i = idx; i + 1 < count; i++) begin
				offs[i] = offs[i + 1];
				lens[i] = lens[i + 1];
				busy[i] = busy[i + 1];
			end
			count--;
		endfunction

		function logic [2:0] allocate(bit [39:0] req, output bit [47:0] got);
			bit [63:0] a, need;
			int best;
			got = 0;
			best = -1;
			a = (align == 0) ? 64'd1 : 64'(align);
			need = ((64'(req) + a - 1) / a) * a;
			if (req == 0)
				return CODE_ZERO;
			for (int i = 0; i < count; i++)
				if (!busy[i] && 64'(lens[i]) >= need &&
						(best < 0 || lens[i] < lens[best]))
					best = i;
			if (best < 0)
				return CODE_NOFIT;
			if (64'(lens[best]) != need) begin
				if (count >= Slots)
					return CODE_FULL;
				for (int i = count; i > best + 1; i--) begin
					offs[i] = offs[i - 1];
					lens[i] = lens[i - 1];
					busy[i] = busy[i - 1];
				end
				offs[best + 1] = offs[best] + need[39:0];
				lens[best + 1] = lens[best] - need[39:0];
				busy[best + 1] = 0;
				lens[best] = need[39:0];
				count++;
			end
			busy[best] = 1;
			got = chunk_address(best);
			return CODE_OK;
		endfunction

		function logic [2:0] release_chunk(bit [47:0] a);
			int i;
			i = locate(a);
			if (i < 0)
				return CODE_UNKNOWN;
			busy[i] = 0;
			if (i + 1 < count && !busy[i + 1]) begin
				lens[i] = lens[i] + lens[i + 1];
				drop_entry(i + 1);
			end
			if (i > 0 && !busy[i - 1]) begin
				lens[i - 1] = lens[i - 1] + lens[i];
				drop_entry(i);
			end
			return CODE_OK;
		endfunction

		function void note_command(logic [1:0] c, logic [39:0] req, logic [47:0] a);
			pool_result_t r;
			bit [63:0] ub, fb, gb, tb;
			int uc, gc, f;
			bit [47:0] got;
			r.addr = 0;
			r.code = CODE_OK;
			r.tracked = 0;
			ub = 0; fb = 0; gb = 0; tb = 0; uc = 0; gc = 0;
			case (c)
				CMD_ALLOC: begin
					r.code = allocate(req, got);
					r.addr = got;
				end
				CMD_FREE: r.code = release_chunk(a);
				CMD_PROBE: begin
					f = locate(a);
					r.tracked = (f >= 0) && busy[f];
				end
				default: ;
			endcase
			for (int i = 0; i < count; i++) begin
				if (busy[i]) begin
					ub += lens[i];
					uc++;
				end else begin
					fb += lens[i];
					if (i + 1 < count) begin
						gb += lens[i];
						gc++;
					end else
						tb = lens[i];
				end
			end
			r.used_bytes = ub[39:0];
			r.used_chunks = uc[6:0];
			r.free_bytes = fb[39:0];
			r.frag_bytes = gb[39:0];
			r.frag_chunks = gc[6:0];
			r.tail_bytes = tb[39:0];
			pending_q.insert(pending_q.size(), r);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_result(pool_result_t got);
			pool_result_t w;
			if (pending_q.size() == 0) begin
				report("result beat with nothing pending", got.code, 0);
				return;
			end
			w = pending_q.pop_front();
			if (got.addr !== w.addr) report("result_address", got.addr, w.addr);
			if (got.code !== w.code) report("code", got.code, w.code);
			if (got.tracked !== w.tracked) report("is_tracked", got.tracked, w.tracked);
			if (got.used_bytes !== w.used_bytes)
				report("allocated_bytes", got.used_bytes, w.used_bytes);
			if (got.used_chunks !== w.used_chunks)
				report("allocated_chunks", got.used_chunks, w.used_chunks);
			if (got.free_bytes !== w.free_bytes)
				report("available_bytes", got.free_bytes, w.free_bytes);
			if (got.frag_bytes !== w.frag_bytes)
				report("fragmented_bytes", got.frag_bytes, w.frag_bytes);
			if (got.frag_chunks !== w.frag_chunks)
				report("fragment_chunks", got.frag_chunks, w.frag_chunks);
			if (got.tail_bytes !== w.tail_bytes)
				report("tail_free_bytes", got.tail_bytes, w.tail_bytes);
		endtask

		// address of a random chunk in the asked busy state, any chunk if none is
		function bit [47:0] pick_chunk(bit want_busy);
			int idx[$];
			for (int i = 0; i < count; i++)
				if (busy[i] == want_busy)
					idx.insert(idx.size(), i);
			if (idx.size() == 0)
				return chunk_address($urandom_range(count - 1));
			return chunk_address(idx[$urandom_range(idx.size() - 1)]);
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 0;
	logic [47:0] cfg_data = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  cmd = 0;
	logic [39:0] request_size = 0;
	logic [47:0] address = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [47:0] result_address;
	logic [2:0]  code;
	logic        is_tracked;
	logic [39:0] allocated_bytes;
	logic [6:0]  allocated_chunks;
	logic [39:0] available_bytes;
	logic [39:0] fragmented_bytes;
	logic [6:0]  fragment_chunks;
	logic [39:0] tail_free_bytes;

	pool_scoreboard sb = new();
	bit calm = 0;
	bit hold = 0;
	int sent = 0;
	int quiet = 0;

	best_fit_pool_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .request_size(request_size), .address(address),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_address(result_address), .code(code), .is_tracked(is_tracked),
		.allocated_bytes(allocated_bytes), .allocated_chunks(allocated_chunks),
		.available_bytes(available_bytes), .fragmented_bytes(fragmented_bytes),
		.fragment_chunks(fragment_chunks), .tail_free_bytes(tail_free_bytes)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= hold ? 1'b0 : (calm ? 1'b1 : ($urandom_range(99) >= 17));
	end

	always @(posedge clk) begin
		pool_result_t r;
		if (arst_n && out_valid && out_ready) begin
			r.addr = result_address;
			r.code = code;
			r.tracked = is_tracked;
			r.used_bytes = allocated_bytes;
			r.used_chunks = allocated_chunks;
			r.free_bytes = available_bytes;
			r.frag_bytes = fragmented_bytes;
			r.frag_chunks = fragment_chunks;
			r.tail_bytes = tail_free_bytes;
			sb.check_result(r);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > StallLimit) begin
			$display("tb_best_fit_pool_allocator NOT OK");
			$finish;
		end
	end

	// one long hold-off on the result side while commands keep coming
	initial begin
		wait (sent >= 600);
		@(posedge clk);
		hold = 1;
		repeat (400) @(posedge clk);
		hold = 0;
	end

	task send_command(logic [1:0] c, logic [39:0] req, logic [47:0] a);
		if (!calm && $urandom_range(99) < 17) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		request_size <= req;
		address <= a;
		do @(posedge clk); while (!in_ready);
		sb.note_command(c, req, a);
		sent++;
	endtask

	task write_reg(logic [1:0] idx, logic [47:0] data);
		in_valid <= 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.configure(idx, data);
		@(posedge clk);
	endtask

	task set_pool(logic [47:0] b, logic [47:0] p, logic [47:0] al);
		write_reg(REG_BASE, b);
		write_reg(REG_POOL, p);
		write_reg(REG_ALIGN, al);
	endtask

	task random_mix(int n, int alloc_pct);
		int p;
		bit [63:0] lim, sz;
		bit [47:0] a;
		for (int k = 0; k < n; k++) begin
			calm = (sent >= 250 && sent < 420);
			p = $urandom_range(99);
			lim = 64'(sb.pool) >> 3;
			if (lim == 0)
				lim = 1;
			if (p < alloc_pct) begin
				p = $urandom_range(99);
				if (p < 3)
					sz = 0;
				else if (p < 10)
					sz = {$urandom, $urandom};
				else
					sz = ({$urandom, $urandom} % lim) + 1;
				send_command(CMD_ALLOC, sz[39:0], 48'({$urandom, $urandom}));
			end else begin
				p = $urandom_range(99);
				if (p < 80)
					a = sb.pick_chunk(1);
				else if (p < 90)
					a = sb.pick_chunk(0);
				else
					a = 48'({$urandom, $urandom});
				p = $urandom_range(99);
				if (p < 70)
					send_command(CMD_FREE, 40'({$urandom, $urandom}), a);
				else if (p < 96)
					send_command(CMD_PROBE, 40'({$urandom, $urandom}), a);
				else
					send_command(CMD_SPARE, 40'({$urandom, $urandom}), a);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset defaults: 1 MiB pool at 0, 256-byte granularity
		send_command(CMD_ALLOC, 40'd0, 48'd0);
		send_command(CMD_ALLOC, 40'hFF_FFFF_FFFF, 48'd0);
		send_command(CMD_ALLOC, 40'd1, 48'd0);
		send_command(CMD_ALLOC, 40'd256, 48'd0);
		send_command(CMD_ALLOC, 40'd1000, 48'd0);
		send_command(CMD_PROBE, 40'd0, 48'h0);
		send_command(CMD_PROBE, 40'd0, 48'h100);
		send_command(CMD_PROBE, 40'd0, 48'h50);
		send_command(CMD_PROBE, 40'd0, 48'hFFFF_FFFF_FFFF);
		send_command(CMD_FREE, 40'd0, 48'h50);
		send_command(CMD_FREE, 40'd0, 48'hFFFF_FFFF_FFFF);
		send_command(CMD_FREE, 40'd0, 48'h100);
		send_command(CMD_FREE, 40'd0, 48'h100);
		send_command(CMD_FREE, 40'd0, 48'h0);
		send_command(CMD_SPARE, 40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_command(CMD_ALLOC, 40'd1047552, 48'd0);
		send_command(CMD_FREE, 40'd0, 48'h200);
		send_command(CMD_ALLOC, 40'd1048576, 48'd0);
		send_command(CMD_FREE, 40'd0, 48'h0);

		// empty pool, then a tiny pool filled until the table runs out
		set_pool(48'h0, 48'h0, 48'h0);
		send_command(CMD_ALLOC, 40'd1, 48'd0);
		send_command(CMD_ALLOC, 40'd0, 48'd0);
		send_command(CMD_PROBE, 40'd0, 48'd0);
		set_pool(48'h0, 48'd100, 48'd1);
		for (int k = 0; k < 65; k++)
			send_command(CMD_ALLOC, 40'd1, 48'd0);
		send_command(CMD_ALLOC, 40'd37, 48'd0);
		random_mix(60, 40);

		set_pool(48'h1000, 48'd1048576, 48'd256);
		random_mix(240, 55);
		set_pool(48'hFFFF_FFFF_F000, 48'd65536, 48'd1);
		random_mix(240, 55);
		set_pool(48'h0, 48'hFFFF_FFFF_FFFF, 48'd65536);
		random_mix(220, 55);
		set_pool(48'hABCD_0000, 48'h1_0000, 48'h0);
		random_mix(220, 55);
		set_pool(48'h7FFF_FFFF_FFFF, 48'h100_0000, 48'h1_FFFF);
		random_mix(280, 55);
		in_valid <= 0;

		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("tb_best_fit_pool_allocator OK");
		else
			$display("tb_best_fit_pool_allocator NOT OK");
		$finish;
	end
endmodule
